// ----- hdl/iard_pkg.sv -----
package iard_pkg;

    localparam int RATE_REGS     = 4;
    localparam int ANALOG_FIELDS = 2;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;
    localparam int LEVEL_W       = 16;
    localparam int STEP_W        = 19;
    localparam int ASUM_W        = 17;
    localparam int SUM_W         = 20;
    localparam int OUT_W         = 18;

    localparam logic signed [LEVEL_W-1:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [LEVEL_W-1:0] RATE_RST_P  = 16'sd10240;
    localparam logic signed [LEVEL_W-1:0] RATE_RST_N  = -16'sd10240;
    localparam logic [14:0]               RETURN_RST  = 15'd10240;
    localparam logic [14:0]               DEADZ_RST   = 15'd16;

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic signed [15:0]        t_rate;
    typedef logic [STEP_W-1:0]         t_step;

    typedef enum logic [2:0] {
        REG_RATE_0      = 3'd0,
        REG_RATE_1      = 3'd1,
        REG_RATE_2      = 3'd2,
        REG_RATE_3      = 3'd3,
        REG_RETURN_RATE = 3'd4,
        REG_DEAD_ZONE   = 3'd5,
        REG_CLAMP_EN    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic update;
        logic pressed;
    } t_lane_ctl;

endpackage

// ----- hdl/input_axis_ramp_deadzone.sv -----
// a result reaches o_axis_value through the lane registers and then the merge register
// throughput: one beat per cycle while not stalled; each button lane updates its level
// in the accept cycle and a registered merge stage sums them with the analog readings
// reset (synchronous, active low) zeroes all button levels, empties the pipeline
// and loads the documented register defaults
module input_axis_ramp_deadzone #(
    parameter int NUM_BUTTONS = 4,
    parameter int NUM_ANALOG  = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beat channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [15:0]                   i_dt_step,
    input  logic [3:0]                    i_pressed_mask,
    input  logic signed [15:0]            i_analog_0,
    input  logic signed [15:0]            i_analog_1,
    // result beat channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [17:0]            o_axis_value,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iard_pkg::ADDR_W-1:0]   paddr,
    input  logic [iard_pkg::DATA_W-1:0]   pwdata,
    output logic [iard_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import iard_pkg::*;

    // only the first four buttons have a rate register and a mask bit
    localparam int RATE_N   = (NUM_BUTTONS < RATE_REGS) ? NUM_BUTTONS : RATE_REGS;
    // analog readings past the two input fields are absent
    localparam int ANALOG_N = (NUM_ANALOG < ANALOG_FIELDS) ? NUM_ANALOG : ANALOG_FIELDS;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    t_rate              r_rate [RATE_N];
    logic [14:0]        r_return_rate;
    logic [14:0]        r_dead_zone;
    logic               r_clamp_en;
    logic               w_cfg_wr;
    logic [2:0]         w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    // registers sit on 32-bit word boundaries
    assign w_cfg_idx = paddr[4:2];

    for (genvar g = 0; g < RATE_N; g++) begin : g_rate
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rate[g] <= (g % 2 == 1) ? RATE_RST_N : RATE_RST_P;
            end else if (w_cfg_wr && w_cfg_idx == 3'(g)) begin
                r_rate[g] <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_return_rate <= RETURN_RST;
            r_dead_zone   <= DEADZ_RST;
            r_clamp_en    <= 1'b1;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_RETURN_RATE: r_return_rate <= pwdata[14:0];
                REG_DEAD_ZONE:   r_dead_zone   <= pwdata[14:0];
                REG_CLAMP_EN:    r_clamp_en    <= pwdata[0];
                default: ;  // rate registers are written above, others are unused
            endcase
        end
    end

    // register readback, rates sign extended to the bus width
    always_comb begin
        prdata = '0;
        case (w_cfg_idx)
            REG_RETURN_RATE: prdata = DATA_W'(r_return_rate);
            REG_DEAD_ZONE:   prdata = DATA_W'(r_dead_zone);
            REG_CLAMP_EN:    prdata = DATA_W'(r_clamp_en);
            default: begin
                for (int i = 0; i < RATE_N; i++) begin
                    if (w_cfg_idx == 3'(i)) begin
                        prdata = DATA_W'(r_rate[i]);
                    end
                end
            end
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline control: lanes form stage one, merge register stage two
    // ---------------------------------------------------------------
    logic               r_s1_valid;
    logic               r_out_valid;
    logic               w_advance;
    logic               w_accept;
    logic               w_load;

    // merge register can take a beat when empty or being drained
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_advance && r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------------------------------------------------------
    // stage one: shared return step, analog sum and the button lanes
    // ---------------------------------------------------------------
    logic [30:0]        w_ret_prod;
    t_step              w_ret_step;
    logic signed [ASUM_W-1:0] w_analog_sum;
    logic signed [ASUM_W-1:0] r_analog_sum;
    t_level             w_levels [NUM_BUTTONS];

    // return rate is non-negative, so the plain shift already truncates toward zero
    assign w_ret_prod = 31'(r_return_rate) * 31'(i_dt_step);
    assign w_ret_step = w_ret_prod[30:12];

    if (ANALOG_N > 1) begin : g_two_analog
        assign w_analog_sum = ASUM_W'(i_analog_0) + ASUM_W'(i_analog_1);
    end else begin : g_one_analog
        assign w_analog_sum = ASUM_W'(i_analog_0);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_analog_sum <= w_analog_sum;
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        t_lane_ctl w_ctl;
        t_rate     w_rate;

        if (g < RATE_N) begin : g_wired
            assign w_ctl.pressed = i_pressed_mask[g];
            assign w_rate        = r_rate[g];
        end else begin : g_unwired
            // no rate and no mask bit: the level just stays at zero
            assign w_ctl.pressed = 1'b0;
            assign w_rate        = '0;
        end
        assign w_ctl.update = w_accept;

        iard_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_rate     (w_rate),
            .i_dt_step  (i_dt_step),
            .i_ret_step (w_ret_step),
            .i_dead_zone(r_dead_zone),
            .o_level    (w_levels[g])
        );
    end

    // ---------------------------------------------------------------
    // stage two: sum, saturate and hold the result beat
    // ---------------------------------------------------------------
    iard_merge #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_load      (w_load),
        .i_levels    (w_levels),
        .i_analog_sum(r_analog_sum),
        .i_clamp_en  (r_clamp_en),
        .o_axis_value(o_axis_value)
    );
endmodule

// ----- hdl/iard_lane.sv -----
module iard_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iard_pkg::t_lane_ctl i_ctl,
    input  iard_pkg::t_rate     i_rate,
    input  logic [15:0]         i_dt_step,
    input  iard_pkg::t_step     i_ret_step,
    input  logic [14:0]         i_dead_zone,
    output iard_pkg::t_level    o_level
);
    import iard_pkg::*;

    t_level              r_level;
    t_level              n_level;
    logic signed [16:0]  w_dt_s;
    logic signed [32:0]  w_prod;
    logic signed [32:0]  w_adj;
    logic signed [20:0]  w_delta;
    logic [15:0]         w_mag;
    logic signed [21:0]  w_next;
    t_level              w_clamped;
    logic [15:0]         w_mag2;

    assign w_dt_s  = $signed({1'b0, i_dt_step});
    assign w_prod  = i_rate * w_dt_s;
    // bias negative products so the shift truncates toward zero
    assign w_adj   = w_prod + (w_prod[32] ? 33'sd4095 : 33'sd0);
    assign w_delta = w_adj[32:12];
    assign w_mag   = r_level[LEVEL_W-1] ? 16'(-r_level) : 16'(r_level);

    always_comb begin
        if (i_ctl.pressed) begin
            w_next = 22'(r_level) + 22'(w_delta);
        end else if (r_level == '0) begin
            w_next = '0;
        end else if ({3'b0, w_mag} <= i_ret_step) begin
            w_next = '0;
        end else if (r_level[LEVEL_W-1]) begin
            w_next = 22'(r_level) + $signed({6'b0, i_ret_step[15:0]});
        end else begin
            w_next = 22'(r_level) - $signed({6'b0, i_ret_step[15:0]});
        end

        if (w_next > 22'(ONE_Q14)) begin
            w_clamped = ONE_Q14;
        end else if (w_next < -22'(ONE_Q14)) begin
            w_clamped = -ONE_Q14;
        end else begin
            w_clamped = w_next[LEVEL_W-1:0];
        end

        w_mag2 = w_clamped[LEVEL_W-1] ? 16'(-w_clamped) : 16'(w_clamped);
        if (w_mag2 != '0 && w_mag2 <= {1'b0, i_dead_zone}) begin
            n_level = '0;
        end else begin
            n_level = w_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_ctl.update) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;
endmodule

// ----- hdl/iard_merge.sv -----
module iard_merge #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  iard_pkg::t_level              i_levels [NUM_BUTTONS],
    input  logic signed [16:0]            i_analog_sum,
    input  logic                          i_clamp_en,
    output logic signed [17:0]            o_axis_value
);
    import iard_pkg::*;

    logic signed [SUM_W-1:0] w_sum;
    logic signed [OUT_W-1:0] n_axis;
    logic signed [OUT_W-1:0] r_axis;

    always_comb begin
        w_sum = SUM_W'(i_analog_sum);
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            w_sum = w_sum + SUM_W'(i_levels[i]);
        end

        if (i_clamp_en) begin
            if (w_sum > SUM_W'(ONE_Q14)) begin
                n_axis = OUT_W'(ONE_Q14);
            end else if (w_sum < -SUM_W'(ONE_Q14)) begin
                n_axis = -OUT_W'(ONE_Q14);
            end else begin
                n_axis = w_sum[OUT_W-1:0];
            end
        end else begin
            if (w_sum > SUM_W'(18'sh1FFFF)) begin
                n_axis = 18'sh1FFFF;
            end else if (w_sum < -SUM_W'(20'sh20000)) begin
                n_axis = 18'sh20000;
            end else begin
                n_axis = w_sum[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_axis <= n_axis;
        end
    end

    assign o_axis_value = r_axis;
endmodule

// ----- tb/sv/tb.sv -----
module tb;
    import iard_pkg::*;

    localparam int NUM_BUTTONS   = 4;
    localparam int NUM_ANALOG    = 2;
    // index past the last register, a write there must change nothing
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PHASES = 7;
    localparam int TICKS_PER_PHASE = 250;

    // one input beat
    typedef struct {
        logic [15:0]        dt;
        logic [3:0]         mask;
        logic signed [15:0] a0;
        logic signed [15:0] a1;
    } t_tick;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [15:0]          i_dt_step = '0;
    logic [3:0]           i_pressed_mask = '0;
    logic signed [15:0]   i_analog_0 = '0;
    logic signed [15:0]   i_analog_1 = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [17:0]   o_axis_value;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // ticks waiting to be driven, and axis values waiting to come out
    t_tick                tick_backlog[$];
    logic signed [17:0]   axis_awaited[$];

    // shadow of the register file and of the button levels, reset values
    longint               rate_q10[NUM_BUTTONS] = '{10240, -10240, 10240, -10240};
    longint               ret_rate_q10 = 10240;
    longint               dead_q14 = 16;
    bit                   clamp_on = 1'b1;
    longint               level_q14[NUM_BUTTONS] = '{0, 0, 0, 0};

    // idle knobs, set per phase
    int unsigned          in_gap_max = 0;
    int unsigned          out_stall_max = 0;
    int unsigned          in_gap = 0;
    int unsigned          out_stall = 0;

    int                   n_errors = 0;
    int                   n_ticks = 0;
    int                   n_queued = 0;
    int                   n_results = 0;
    int                   n_settings = 0;
    t_tick                cur;

    input_axis_ramp_deadzone #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .NUM_ANALOG  (NUM_ANALOG)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_dt_step      (i_dt_step),
        .i_pressed_mask (i_pressed_mask),
        .i_analog_0     (i_analog_0),
        .i_analog_1     (i_analog_1),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_axis_value   (o_axis_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // rate (Q6.10) times dt (Q0.16) down to Q1.14, truncated toward zero
    function automatic longint dt_scaled(longint rate, logic [15:0] dt);
        longint prod;
        prod = rate * longint'(dt);
        if (prod < 0)
            return -((-prod) >>> 12);
        return prod >>> 12;
    endfunction

    // advance the shadow levels by one tick and return the axis value
    function automatic logic signed [17:0] next_axis_value(t_tick t);
        longint sum;
        longint lvl;
        longint stp;
        longint mag;
        sum = longint'(t.a0) + longint'(t.a1);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            lvl = level_q14[b];
            if (t.mask[b]) begin
                lvl = lvl + dt_scaled(rate_q10[b], t.dt);
            end else if (lvl != 0) begin
                // return toward zero without crossing it
                stp = dt_scaled(ret_rate_q10, t.dt);
                mag = (lvl < 0) ? -lvl : lvl;
                if (stp >= mag)
                    lvl = 0;
                else
                    lvl = (lvl > 0) ? lvl - stp : lvl + stp;
            end
            if (lvl > 16384)
                lvl = 16384;
            else if (lvl < -16384)
                lvl = -16384;
            mag = (lvl < 0) ? -lvl : lvl;
            if (mag != 0 && mag <= dead_q14)
                lvl = 0;
            level_q14[b] = lvl;
            sum = sum + lvl;
        end
        if (clamp_on) begin
            if (sum > 16384)
                sum = 16384;
            if (sum < -16384)
                sum = -16384;
        end else begin
            // 18-bit saturation when the clamp is off
            if (sum > 131071)
                sum = 131071;
            if (sum < -131072)
                sum = -131072;
        end
        return 18'(sum);
    endfunction

    // sender: hold the beat until taken, then wait the drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                // beat taken, predict it with the settings now in force
                axis_awaited = {axis_awaited, next_axis_value(cur)};
                n_ticks++;
            end
            if (i_in_valid && !o_in_ready) begin
                // keep valid and payload steady
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (tick_backlog.size() > 0) begin
                cur = tick_backlog.pop_front();
                i_dt_step      <= cur.dt;
                i_pressed_mask <= cur.mask;
                i_analog_0     <= cur.a0;
                i_analog_1     <= cur.a1;
                i_in_valid     <= 1'b1;
                in_gap = $urandom_range(0, in_gap_max);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: compare each result beat, then stall for the drawn count
    always @(posedge i_clk) begin
        logic signed [17:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (axis_awaited.size() == 0) begin
                    $display("%0t: axis_value %0d with no tick outstanding, expected none",
                             $time, o_axis_value);
                    n_errors++;
                end else begin
                    want = axis_awaited.pop_front();
                    if (want !== o_axis_value) begin
                        $display("%0t: axis_value mismatch, expected %0d, actual %0d",
                                 $time, want, o_axis_value);
                        n_errors++;
                    end
                end
                out_stall = $urandom_range(0, out_stall_max);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // register write with a setup and an access phase, then mirror it in the shadow copy
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RATE_0, REG_RATE_1, REG_RATE_2, REG_RATE_3:
                rate_q10[idx] = longint'($signed(val[15:0]));
            REG_RETURN_RATE: ret_rate_q10 = longint'(val[14:0]);
            REG_DEAD_ZONE:   dead_q14 = longint'(val[14:0]);
            REG_CLAMP_EN:    clamp_on = val[0];
            default: ;
        endcase
    endtask

    task automatic queue_tick(input logic [15:0] dt, input logic [3:0] mask,
                              input logic signed [15:0] a0, input logic signed [15:0] a1);
        t_tick t;
        t.dt = dt;
        t.mask = mask;
        t.a0 = a0;
        t.a1 = a1;
        tick_backlog = {tick_backlog, t};
        n_queued++;
    endtask

    // a mix of short and full-range steps, with full-range readings now and then
    task automatic queue_random_tick();
        logic [15:0]        dt;
        logic signed [15:0] a0;
        logic signed [15:0] a1;
        case ($urandom_range(0, 9))
            0:          dt = 16'd0;
            1:          dt = 16'hFFFF;
            2, 3, 4, 5: dt = 16'($urandom_range(0, 1023));
            default:    dt = 16'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 4) != 0) begin
            a0 = 16'(int'($urandom_range(0, 32768)) - 16384);
            a1 = 16'(int'($urandom_range(0, 32768)) - 16384);
        end else begin
            a0 = 16'($urandom);
            a1 = 16'($urandom);
        end
        queue_tick(dt, 4'($urandom_range(0, 15)), a0, a1);
    endtask

    // block until every queued tick has come back as a checked result
    task automatic wait_drained();
        while (n_results < n_queued)
            @(posedge i_clk);
        // lane and merge register stages plus margin
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int p;
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: ramps, partial return, dead zone snap, output clamp
        n_settings++;
        queue_tick(16'd0,     4'h0, 16'sd0,      16'sd0);
        queue_tick(16'd0,     4'hF, 16'sd16384,  -16'sd16384);
        queue_tick(16'hFFFF,  4'hF, 16'sd0,      16'sd0);       // levels slam to the rails
        queue_tick(16'hFFFF,  4'h0, 16'sd0,      16'sd0);       // full return to zero
        queue_tick(16'd100,   4'h1, 16'sd0,      16'sd0);
        queue_tick(16'd1,     4'h1, 16'sd0,      16'sd0);
        queue_tick(16'hFFFF,  4'h0, 16'sd0,      16'sd0);
        queue_tick(16'd8,     4'h2, 16'sd0,      16'sd0);       // just outside the dead zone
        queue_tick(16'd2,     4'h0, 16'sd0,      16'sd0);       // partial return lands inside it
        queue_tick(16'd6,     4'h1, 16'sd0,      16'sd0);       // ramp too small, snaps
        queue_tick(16'd0,     4'h0, 16'sd32767,  16'sd32767);   // readings out of range
        queue_tick(16'd0,     4'h0, -16'sd32768, -16'sd32768);
        queue_tick(16'd3000,  4'h5, 16'sd16384,  16'sd0);
        queue_tick(16'hFFFF,  4'h5, -16'sd32768, 16'sd0);
        wait_drained();

        // extreme rates, no return, dead zone of 16384, clamp off
        n_settings++;
        write_reg(REG_RATE_0, 32'h0000_7FFF);
        write_reg(REG_RATE_1, 32'hFFFF_8000);
        write_reg(REG_RATE_2, 32'h0000_0001);
        write_reg(REG_RATE_3, 32'hFFFF_FFFF);
        write_reg(REG_RETURN_RATE, 32'd0);
        write_reg(REG_DEAD_ZONE, 32'd16384);
        write_reg(REG_CLAMP_EN, 32'd0);
        queue_tick(16'hFFFF,  4'hF, 16'sd100,    -16'sd100);
        queue_tick(16'hFFFF,  4'h4, 16'sd0,      16'sd0);
        queue_tick(16'hFFFF,  4'h0, 16'sd1,      16'sd1);
        wait_drained();

        // full return rate, no dead zone, unclamped sums beyond the clamp range
        n_settings++;
        write_reg(REG_RATE_0, 32'hFFFF_8000);
        write_reg(REG_RATE_1, 32'h0000_7FFF);
        write_reg(REG_RATE_2, 32'h0000_7FFF);
        write_reg(REG_RATE_3, 32'hFFFF_8000);
        write_reg(REG_RETURN_RATE, 32'h0000_7FFF);
        write_reg(REG_DEAD_ZONE, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);                  // must be ignored
        queue_tick(16'hFFFF,  4'hF, 16'sd32767,  16'sd32767);
        queue_tick(16'hFFFF,  4'h6, 16'sd32767,  16'sd32767);
        queue_tick(16'hFFFF,  4'h6, -16'sd32768, -16'sd32768);
        queue_tick(16'hFFFF,  4'h9, -16'sd32768, -16'sd32768);
        queue_tick(16'd0,     4'h0, 16'sd0,      16'sd0);       // release with no time, no change
        queue_tick(16'd1,     4'h0, 16'sd0,      16'sd0);
        queue_tick(16'd40,    4'h0, 16'sd0,      16'sd0);
        wait_drained();

        // random settings per phase, random ticks within each
        for (p = 0; p < RANDOM_PHASES; p++) begin
            n_settings++;
            for (k = 0; k < RATE_REGS; k++)
                write_reg(3'(k), $urandom_range(0, 4) == 0 ?
                          32'($urandom) : 32'(int'($urandom_range(0, 24576)) - 12288));
            write_reg(REG_RETURN_RATE, $urandom_range(0, 2) == 0 ?
                      32'($urandom_range(0, 32767)) : 32'($urandom_range(0, 12000)));
            write_reg(REG_DEAD_ZONE, $urandom_range(0, 5) == 0 ?
                      32'($urandom_range(0, 32767)) : 32'($urandom_range(0, 300)));
            write_reg(REG_CLAMP_EN, 32'($urandom_range(0, 1)));
            // some phases run with one side or both never idling
            in_gap_max    = (p % 3 == 0) ? 0 : 6;
            out_stall_max = (p % 2 == 0) ? 6 : 0;
            for (k = 0; k < TICKS_PER_PHASE; k++) begin
                queue_random_tick();
                // sender holds off until the pipeline has emptied
                if (p == 2 && k == TICKS_PER_PHASE / 2) begin
                    while (n_results < n_queued)
                        @(posedge i_clk);
                end
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d ticks driven and %0d axis values checked over %0d register settings,",
                 n_ticks, n_results, n_settings);
        $display("with stalls on both sides and ramps, returns, snaps and both clamp modes");
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
